>>> sv/obpd_pkg.sv
// ----------------------------------------------------------------------------
// obpd_pkg: shared types and constants of the oriented box decoder
// Holds the register map, the job record passed from front to back and
// the divider sizing.
// ----------------------------------------------------------------------------
`default_nettype none
package obpd_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_LAYOUT = 3'd0;
  localparam logic [2:0] REG_CLASSES = 3'd1;
  localparam logic [2:0] REG_LIMIT = 3'd2;
  localparam logic [2:0] REG_MWIDTH = 3'd3;
  localparam logic [2:0] REG_MHEIGHT = 3'd4;

  // One bit per cycle over a 34-bit numerator magnitude.
  localparam int DIV_STEPS = 34;
  localparam int NUM_QUOTS = 8;

  // A kept row as handed to the back end.
  typedef struct packed {
    logic [7:0]         image;
    logic [6:0]         label;
    logic [30:0]        score;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] w;
    logic signed [31:0] h;
    logic signed [31:0] angle;
    logic [12:0]        mw;
    logic [12:0]        mh;
  } job_t;

endpackage
`default_nettype wire

>>> sv/obpd_front.sv
// ----------------------------------------------------------------------------
// obpd_front: row element intake and classification
// Tracks the place of each element in a row, keeps the geometry and the best
// class, and at row end pushes a job for every kept row.
// ----------------------------------------------------------------------------
`default_nettype none
module obpd_front #(
  parameter int MAX_CLASSES = 128,
  parameter int VALUE_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_field_value,
  input  wire logic [7:0]         in_batch_index,
  input  wire logic               layout_mode,
  input  wire logic [7:0]         class_count,
  input  wire logic [16:0]        score_limit,
  input  wire logic [12:0]        model_width,
  input  wire logic [12:0]        model_height,
  input  wire logic               q_full,
  output logic                    q_push,
  output obpd_pkg::job_t          q_job
);
  import obpd_pkg::*;

  localparam int SHIFT = 32 - VALUE_BITS;
  localparam logic [7:0] MAXC = 8'(MAX_CLASSES);

  logic [7:0]         pos_r, pos_nxt;
  logic signed [31:0] geo_r [4];
  logic signed [31:0] best_score_r, best_score_nxt;
  logic [7:0]         best_class_r, best_class_nxt;
  logic               found_r, found_nxt;

  logic signed [31:0] v_sh, v;
  logic [7:0]         n, last;
  logic               accept, row_end, kept, id_ok;
  logic [7:0]         id;

  // Only the low value bits of an element are used, sign-extended.
  always_comb begin
    v_sh = in_field_value <<< SHIFT;
    v = v_sh >>> SHIFT;
  end

  assign n = (class_count > MAXC) ? MAXC : class_count;
  assign last = layout_mode ? 8'd6 : 8'd4 + n;
  assign row_end = pos_r >= last;
  assign in_stall = q_full;
  assign accept = in_valid && !in_stall;

  // Class id truncated toward zero; values in (-1, 0) give class zero.
  always_comb begin
    id = 8'd0;
    id_ok = 1'b0;
    if (!v[31]) begin
      id = v[23:16];
      id_ok = ({16'd0, v[31:16]} < {24'd0, n});
    end else if (v[31:16] == 16'hFFFF && v[15:0] != 16'd0) begin
      id_ok = (n != 8'd0);
    end
  end

  // Running best score and class for the current row.
  always_comb begin
    best_score_nxt = (pos_r == 8'd0) ? 32'sd0 : best_score_r;
    best_class_nxt = (pos_r == 8'd0) ? 8'd0 : best_class_r;
    found_nxt = (pos_r == 8'd0) ? 1'b0 : found_r;
    pos_nxt = pos_r + 8'd1;
    if (row_end) begin
      pos_nxt = 8'd0;
    end else if (pos_r >= 8'd4) begin
      if (!layout_mode) begin
        if (v > best_score_nxt) begin
          best_score_nxt = v;
          best_class_nxt = pos_r - 8'd4;
          found_nxt = 1'b1;
        end
      end else if (pos_r == 8'd4) begin
        best_score_nxt = v;
      end else begin
        best_class_nxt = id;
        found_nxt = id_ok;
      end
    end
  end

  assign kept = found_r && (best_score_r >= $signed({15'd0, score_limit}));
  assign q_push = accept && row_end && kept;

  // Job record for a kept row.
  always_comb begin
    q_job.image = in_batch_index;
    q_job.label = best_class_r[6:0];
    q_job.score = best_score_r[30:0];
    q_job.cx = geo_r[0];
    q_job.cy = geo_r[1];
    q_job.w = geo_r[2];
    q_job.h = geo_r[3];
    q_job.angle = v;
    q_job.mw = (model_width == 13'd0) ? 13'd1 : model_width;
    q_job.mh = (model_height == 13'd0) ? 13'd1 : model_height;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 8'd0;
      best_score_r <= 32'sd0;
      best_class_r <= 8'd0;
      found_r <= 1'b0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      best_score_r <= best_score_nxt;
      best_class_r <= best_class_nxt;
      found_r <= found_nxt;
    end
  end

  // Geometry elements sit in the first four places of a row.
  always_ff @(posedge clk) begin
    if (accept && pos_r < 8'd4) begin
      geo_r[pos_r[1:0]] <= v;
    end
  end

endmodule
`default_nettype wire

>>> sv/obpd_queue.sv
// ----------------------------------------------------------------------------
// obpd_queue: two-entry job queue
// Decouples the element intake from the division back end.
// ----------------------------------------------------------------------------
`default_nettype none
module obpd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire obpd_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output obpd_pkg::job_t      head
);
  import obpd_pkg::*;

  job_t       mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= 1'b0;
      rd_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> sv/obpd_back.sv
// ----------------------------------------------------------------------------
// obpd_back: box scaling back end
// Works out the eight scaled box values of a job with one shared
// bit-serial divider, saturates them and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none
module obpd_back #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_not_empty,
  input  wire obpd_pkg::job_t     q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_image_index,
  output logic [6:0]              out_label,
  output logic [30:0]             out_score,
  output logic signed [31:0]      out_centre_x,
  output logic signed [31:0]      out_centre_y,
  output logic signed [31:0]      out_box_width,
  output logic signed [31:0]      out_box_height,
  output logic signed [31:0]      out_rotation,
  output logic signed [31:0]      out_left,
  output logic signed [31:0]      out_top,
  output logic signed [31:0]      out_right,
  output logic signed [31:0]      out_bottom
);
  import obpd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV = 2'd2;
  localparam logic [1:0] ST_OUT = 2'd3;

  localparam logic signed [34:0] SAT_HI = 35'sd2 ** (VALUE_BITS - 1) - 35'sd1;
  localparam logic signed [34:0] SAT_LO = -SAT_HI - 35'sd1;
  localparam logic [5:0] LAST_STEP = 6'(DIV_STEPS - 1);

  logic [1:0]         state_r;
  job_t               job_r;
  logic [2:0]         k_r;
  logic [5:0]         cnt_r;
  logic [33:0]        q_r;
  logic [13:0]        rem_r;
  logic [13:0]        den_r;
  logic               neg_r;
  logic signed [31:0] res_r [NUM_QUOTS];

  logic signed [33:0] cx, cy, w, h, num;
  logic [13:0]        den;
  logic [14:0]        rem_sh;
  logic               ge;
  logic [33:0]        q_fin;
  logic signed [34:0] sq, sat;

  // Numerator and divisor of quotient k.
  always_comb begin
    cx = 34'(job_r.cx);
    cy = 34'(job_r.cy);
    w = 34'(job_r.w);
    h = 34'(job_r.h);
    case (k_r)
      3'd0: num = cx;
      3'd1: num = cy;
      3'd2: num = w;
      3'd3: num = h;
      3'd4: num = (cx <<< 1) - w;
      3'd5: num = (cy <<< 1) - h;
      3'd6: num = (cx <<< 1) + w;
      default: num = (cy <<< 1) + h;
    endcase
    case (k_r)
      3'd0, 3'd2: den = {1'b0, job_r.mw};
      3'd1, 3'd3: den = {1'b0, job_r.mh};
      3'd4, 3'd6: den = {job_r.mw, 1'b0};
      default: den = {job_r.mh, 1'b0};
    endcase
  end

  // One restoring division step.
  assign rem_sh = {rem_r, q_r[33]};
  assign ge = rem_sh >= {1'b0, den_r};

  // The last step's quotient bit joins the quotient directly.
  assign q_fin = {q_r[32:0], ge};

  // Sign and saturation of the finished quotient.
  always_comb begin
    sq = neg_r ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
    if (sq > SAT_HI) sat = SAT_HI;
    else if (sq < SAT_LO) sat = SAT_LO;
    else sat = sq;
  end

  assign q_pop = (state_r == ST_IDLE) && q_not_empty;
  assign out_valid = (state_r == ST_OUT);

  // Sequencer over the eight quotients.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r <= 3'd0;
      cnt_r <= 6'd0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_not_empty) begin
            k_r <= 3'd0;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt_r <= 6'd0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_r == LAST_STEP) begin
            k_r <= k_r + 3'd1;
            state_r <= (k_r == 3'(NUM_QUOTS - 1)) ? ST_OUT : ST_LOAD;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        ST_OUT: begin
          if (!out_stall) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_head;
    if (state_r == ST_LOAD) begin
      q_r <= num[33] ? 34'(-num) : 34'(num);
      neg_r <= num[33];
      den_r <= den;
      rem_r <= 14'd0;
    end else if (state_r == ST_DIV) begin
      if (cnt_r == LAST_STEP) begin
        res_r[k_r] <= sat[31:0];
      end else begin
        rem_r <= ge ? 14'(rem_sh - {1'b0, den_r}) : rem_sh[13:0];
        q_r <= {q_r[32:0], ge};
      end
    end
  end

  // Result fields come straight from the job and the quotient registers.
  assign out_image_index = job_r.image;
  assign out_label = job_r.label;
  assign out_score = job_r.score;
  assign out_rotation = job_r.angle;
  assign out_centre_x = res_r[0];
  assign out_centre_y = res_r[1];
  assign out_box_width = res_r[2];
  assign out_box_height = res_r[3];
  assign out_left = res_r[4];
  assign out_top = res_r[5];
  assign out_right = res_r[6];
  assign out_bottom = res_r[7];

  // A job is only taken from a queue that holds one.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("pop from empty job queue");

  // A stalled result beat stays on the port.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result beat dropped while stalled");

  // The step counter never runs past the numerator width.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= LAST_STEP))
    else $error("divider step counter out of range");

endmodule
`default_nettype wire

>>> sv/oriented_box_prediction_decoder.sv
// ----------------------------------------------------------------------------
// oriented_box_prediction_decoder: oriented box prediction decoder
// Decodes prediction rows streamed one Q16.16 element per beat into scaled
// oriented boxes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one row element per beat (in_valid / in_stall);
//   in mode 0 a row is cx, cy, w, h, one score per class, angle, and in
//   mode 1 it is cx, cy, w, h, score, class id, angle.
//   Elements are taken one per cycle unless stalled. At the last element of a
//   kept row a job enters a two-entry queue; a dropped row gives no beat.
//   The back end works the eight scaled values in turn with one bit-serial
//   divider, a load state and then the division steps for each, and takes
//   a new job only after the result beat has gone. Elements go in one per
//   cycle while the queue has room, and in_stall rises when it is full.
//   A result beat holds on the out_ ports while out_stall is high, and the
//   front keeps taking elements meanwhile until the queue is full.
//   Reset empties the queue, clears the row position and loads the register
//   defaults (mode 0, 80 classes, limit 0.25, 1024 x 1024). Registers must be
//   written over the APB-style port while the block is idle (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none
module oriented_box_prediction_decoder #(
  parameter int MAX_CLASSES = 128,
  parameter int VALUE_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_field_value,
  input  wire logic [7:0]         in_batch_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_image_index,
  output logic [6:0]              out_label,
  output logic [30:0]             out_score,
  output logic signed [31:0]      out_centre_x,
  output logic signed [31:0]      out_centre_y,
  output logic signed [31:0]      out_box_width,
  output logic signed [31:0]      out_box_height,
  output logic signed [31:0]      out_rotation,
  output logic signed [31:0]      out_left,
  output logic signed [31:0]      out_top,
  output logic signed [31:0]      out_right,
  output logic signed [31:0]      out_bottom,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import obpd_pkg::*;

  logic        layout_mode_r;
  logic [7:0]  class_count_r;
  logic [16:0] score_limit_r;
  logic [12:0] model_width_r;
  logic [12:0] model_height_r;

  logic        q_full, q_push, q_pop, q_not_empty;
  job_t        q_job, q_head;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_mode_r <= 1'b0;
      class_count_r <= 8'd80;
      score_limit_r <= 17'd16384;
      model_width_r <= 13'd1024;
      model_height_r <= 13'd1024;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_LAYOUT: layout_mode_r <= pwdata[0];
        REG_CLASSES: class_count_r <= pwdata[7:0];
        REG_LIMIT: score_limit_r <= pwdata[16:0];
        REG_MWIDTH: model_width_r <= pwdata[12:0];
        REG_MHEIGHT: model_height_r <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[4:2])
      REG_LAYOUT: prdata = {31'd0, layout_mode_r};
      REG_CLASSES: prdata = {24'd0, class_count_r};
      REG_LIMIT: prdata = {15'd0, score_limit_r};
      REG_MWIDTH: prdata = {19'd0, model_width_r};
      REG_MHEIGHT: prdata = {19'd0, model_height_r};
      default: prdata = 32'd0;
    endcase
  end

  obpd_front #(
    .MAX_CLASSES(MAX_CLASSES),
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_field_value(in_field_value),
    .in_batch_index(in_batch_index),
    .layout_mode(layout_mode_r),
    .class_count(class_count_r),
    .score_limit(score_limit_r),
    .model_width(model_width_r),
    .model_height(model_height_r),
    .q_full(q_full),
    .q_push(q_push),
    .q_job(q_job)
  );

  obpd_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_job(q_job),
    .full(q_full),
    .pop(q_pop),
    .not_empty(q_not_empty),
    .head(q_head)
  );

  obpd_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_not_empty(q_not_empty),
    .q_head(q_head),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_image_index(out_image_index),
    .out_label(out_label),
    .out_score(out_score),
    .out_centre_x(out_centre_x),
    .out_centre_y(out_centre_y),
    .out_box_width(out_box_width),
    .out_box_height(out_box_height),
    .out_rotation(out_rotation),
    .out_left(out_left),
    .out_top(out_top),
    .out_right(out_right),
    .out_bottom(out_bottom)
  );

endmodule
`default_nettype wire
